// File: src/lmpd_pkg.sv
// Shared types and constants for the label mask pyramid-down unit.
// Used by the top level and its port checker; no dependencies.
package lmpd_pkg;

    // Label priority levels; the block level is the max over its pixels.
    typedef enum logic [1:0] {
        LVL_SEARCH = 2'd0,
        LVL_BACK   = 2'd1,
        LVL_HOLE   = 2'd2
    } level_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int DIM_W       = 13;
    localparam int ROW_W       = 12;
    localparam int LABEL_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOLE_CODE    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BACK_CODE    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEARCH_CODE  = 3'd4;

    localparam logic [DIM_W-1:0]   RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0]   RST_IMAGE_HEIGHT = 13'd480;
    localparam logic [LABEL_W-1:0] RST_HOLE_CODE    = 8'd0;
    localparam logic [LABEL_W-1:0] RST_BACK_CODE    = 8'd128;
    localparam logic [LABEL_W-1:0] RST_SEARCH_CODE  = 8'd255;

    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 13'd4096;

    // Request held between the line-store read and the result register.
    typedef struct packed {
        logic       valid;
        logic [1:0] horiz;      // level of the horizontal pair
        logic       use_store;  // bottom-half row: merge the stored level
        logic       last;       // last result of the frame
    } stage_t;

    function automatic logic [1:0] max_level(input logic [1:0] a, input logic [1:0] b);
        max_level = (a > b) ? a : b;
    endfunction

endpackage

// File: src/lmpd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module lmpd_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: src/label_mask_pyramid_down_unit.sv
// Top level of the 2x2 priority downsampler for an 8-bit label mask.
// Depends on lmpd_pkg and lmpd_ram (line store of top-half levels).

// Takes one mask pixel per cycle in raster order and emits one label per
// 2x2 block (hole over back over search), flagging the frame's last result.
// Sustained rate is one pixel per clock while in_ready stays high. A result
// is loaded into the stage register when its block's last pixel is
// accepted, then into the output register; the stage register covers
// the registered read of the line store. Input keeps flowing while a
// result waits, as long as the stage register holds no second result.
// The line store needs no clearing: every entry a bottom row reads was
// written by the row above it in the same frame.
module label_mask_pyramid_down_unit #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lmpd_pkg::LABEL_W-1:0]        in_pixel,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lmpd_pkg::LABEL_W-1:0]        out_label,
    output logic                                frame_end,
    input  logic                                cfg_wr_en,
    input  logic [lmpd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lmpd_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int COL_W   = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
    localparam int CMP_W   = (COL_W + 1 > lmpd_pkg::DIM_W) ? COL_W + 1 : lmpd_pkg::DIM_W;
    localparam int DEPTH   = (MAX_WIDTH + 1) / 2;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Configuration registers
    logic [lmpd_pkg::DIM_W-1:0]   image_width_reg;
    logic [lmpd_pkg::DIM_W-1:0]   image_height_reg;
    logic [lmpd_pkg::LABEL_W-1:0] hole_code_reg;
    logic [lmpd_pkg::LABEL_W-1:0] back_code_reg;
    logic [lmpd_pkg::LABEL_W-1:0] search_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= lmpd_pkg::RST_IMAGE_WIDTH;
            image_height_reg <= lmpd_pkg::RST_IMAGE_HEIGHT;
            hole_code_reg    <= lmpd_pkg::RST_HOLE_CODE;
            back_code_reg    <= lmpd_pkg::RST_BACK_CODE;
            search_code_reg  <= lmpd_pkg::RST_SEARCH_CODE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lmpd_pkg::CFG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                lmpd_pkg::CFG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                lmpd_pkg::CFG_HOLE_CODE:    hole_code_reg    <= cfg_data[lmpd_pkg::LABEL_W-1:0];
                lmpd_pkg::CFG_BACK_CODE:    back_code_reg    <= cfg_data[lmpd_pkg::LABEL_W-1:0];
                lmpd_pkg::CFG_SEARCH_CODE:  search_code_reg  <= cfg_data[lmpd_pkg::LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    // Counters and pair level
    logic [COL_W-1:0]          column_count_reg, column_count_next;
    logic [lmpd_pkg::ROW_W-1:0] row_count_reg, row_count_next;
    logic [1:0]                pair_level_reg, pair_level_next;

    lmpd_pkg::stage_t stage_reg, stage_next;

    logic                         out_valid_reg, out_valid_next;
    logic [lmpd_pkg::LABEL_W-1:0] out_label_reg, out_label_next;
    logic                         frame_end_reg, frame_end_next;

    logic                         out_take;
    logic                         accept;

    // Effective geometry
    logic [CMP_W-1:0]           width_raw, width_eff, col_ext, idx_ext;
    logic [lmpd_pkg::DIM_W-1:0] height_eff;
    logic                       last_col, last_row, odd_col, odd_row, pair_done;
    logic [1:0]                 pixel_lvl, horiz;
    logic [ADDR_W-1:0]          store_addr;
    logic                       store_wr, store_rd, emit;
    logic [1:0]                 store_level;

    always_comb
    begin
        width_raw = CMP_W'(image_width_reg);
        if (width_raw == '0)
        begin
            width_eff = CMP_W'(1);
        end
        else if (width_raw > CMP_W'(MAX_WIDTH))
        begin
            width_eff = CMP_W'(MAX_WIDTH);
        end
        else
        begin
            width_eff = width_raw;
        end

        if (image_height_reg == '0)
        begin
            height_eff = lmpd_pkg::DIM_W'(1);
        end
        else if (image_height_reg > lmpd_pkg::HEIGHT_LIMIT)
        begin
            height_eff = lmpd_pkg::HEIGHT_LIMIT;
        end
        else
        begin
            height_eff = image_height_reg;
        end

        col_ext  = CMP_W'(column_count_reg);
        last_col = col_ext >= (width_eff - CMP_W'(1));
        last_row = lmpd_pkg::DIM_W'(row_count_reg) >= (height_eff - lmpd_pkg::DIM_W'(1));
        odd_col  = column_count_reg[0];
        odd_row  = row_count_reg[0];

        idx_ext = col_ext >> 1;
        if (idx_ext > CMP_W'(DEPTH - 1))
        begin
            idx_ext = CMP_W'(DEPTH - 1);
        end
        store_addr = idx_ext[ADDR_W-1:0];

        if (in_pixel == hole_code_reg)
        begin
            pixel_lvl = lmpd_pkg::LVL_HOLE;
        end
        else if (in_pixel == back_code_reg)
        begin
            pixel_lvl = lmpd_pkg::LVL_BACK;
        end
        else
        begin
            pixel_lvl = lmpd_pkg::LVL_SEARCH;
        end

        horiz     = odd_col ? lmpd_pkg::max_level(pair_level_reg, pixel_lvl) : pixel_lvl;
        pair_done = odd_col || last_col;
        emit      = pair_done && (odd_row || last_row);
        store_wr  = accept && pair_done && !odd_row && !last_row;
        store_rd  = accept && pair_done && odd_row;
    end

    assign out_take = !out_valid_reg || out_ready;
    assign in_ready = !stage_reg.valid || out_take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        pair_level_next   = pair_level_reg;
        if (accept)
        begin
            pair_level_next = horiz;
            if (last_col)
            begin
                column_count_next = '0;
                row_count_next    = last_row ? '0 : row_count_reg + 1'b1;
            end
            else
            begin
                column_count_next = column_count_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        if (in_ready)
        begin
            stage_next.valid     = accept && emit;
            stage_next.horiz     = horiz;
            stage_next.use_store = odd_row;
            stage_next.last      = last_col && last_row;
        end
    end

    // Result: merge the stored top-half level for bottom rows, then map to a code
    always_comb
    begin
        logic [1:0] blk;
        blk = stage_reg.use_store ? lmpd_pkg::max_level(stage_reg.horiz, store_level)
                                  : stage_reg.horiz;
        out_valid_next = out_valid_reg;
        out_label_next = out_label_reg;
        frame_end_next = frame_end_reg;
        if (out_take)
        begin
            out_valid_next = stage_reg.valid;
            frame_end_next = stage_reg.last;
            case (blk)
                lmpd_pkg::LVL_HOLE: out_label_next = hole_code_reg;
                lmpd_pkg::LVL_BACK: out_label_next = back_code_reg;
                default:            out_label_next = search_code_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= '0;
            row_count_reg    <= '0;
            pair_level_reg   <= '0;
            stage_reg        <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            pair_level_reg   <= pair_level_next;
            stage_reg        <= stage_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_label_reg <= out_label_next;
        frame_end_reg <= frame_end_next;
    end

    // Reads happen only on accepted bottom-row requests, so the read data
    // holds while the stage register is stalled.
    lmpd_ram #(
        .WIDTH (2),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (store_wr),
        .wr_addr (store_addr),
        .wr_data (horiz),
        .rd_en   (store_rd),
        .rd_addr (store_addr),
        .rd_data (store_level)
    );

    assign out_valid = out_valid_reg;
    assign out_label = out_label_reg;
    assign frame_end = frame_end_reg;

endmodule

// File: src/lmpd_checker.sv
// Port-level checker for label_mask_pyramid_down_unit, bound to the top level.
// Depends on lmpd_pkg for register indexes and reset values.
module lmpd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic [lmpd_pkg::LABEL_W-1:0]     in_pixel,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [lmpd_pkg::LABEL_W-1:0]     out_label,
    input logic                             frame_end,
    input logic                             cfg_wr_en,
    input logic [lmpd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input logic [lmpd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // Shadow copies of the label codes, tracked from the config port
    logic [lmpd_pkg::LABEL_W-1:0] hole_reg, back_reg, search_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hole_reg   <= lmpd_pkg::RST_HOLE_CODE;
            back_reg   <= lmpd_pkg::RST_BACK_CODE;
            search_reg <= lmpd_pkg::RST_SEARCH_CODE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                lmpd_pkg::CFG_HOLE_CODE:   hole_reg   <= cfg_data[lmpd_pkg::LABEL_W-1:0];
                lmpd_pkg::CFG_BACK_CODE:   back_reg   <= cfg_data[lmpd_pkg::LABEL_W-1:0];
                lmpd_pkg::CFG_SEARCH_CODE: search_reg <= cfg_data[lmpd_pkg::LABEL_W-1:0];
                default: ;
            endcase
        end
    end

    // A waiting input request holds its pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_pixel))
        else $error("stalled input request changed");

    // A stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_label) && $stable(frame_end))
        else $error("stalled result changed");

    // Every result carries one of the three configured codes
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_label == hole_reg) || (out_label == back_reg)
                      || (out_label == search_reg))
        else $error("result label is not a configured code");

    // Input is held off only by a result waiting downstream
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // With the output empty, input is ready
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input not ready with output empty");

endmodule

bind label_mask_pyramid_down_unit lmpd_checker u_lmpd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_label (out_label),
    .frame_end (frame_end),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
